@@ rtl/bcne_pkg.sv @@
// shared widths, defaults, operation codes and sequencer states of the neighbourhood engine
package bcne_pkg;

  // payload field widths
  localparam int FUNC_W   = 2;
  localparam int VERTEX_W = 6;
  localparam int COLOUR_W = 4;
  localparam int MASK_W   = 10;
  localparam int SIZE_W   = 4;
  localparam int COUNT_W  = 7;

  // default geometry
  localparam int VERTICES_DEFAULT = 64;
  localparam int COLOURS_DEFAULT  = 10;

  // operation codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD_EDGE   = 2'd0,
    FUNC_SET_LIST   = 2'd1,
    FUNC_SET_COLOUR = 2'd2,
    FUNC_QUERY      = 2'd3
  } func_e;

  // sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EDGE_RD_V,
    ST_EDGE_WR_V,
    ST_EDGE_RD_W,
    ST_EDGE_WR_W,
    ST_ATTR_RD,
    ST_ATTR_WR,
    ST_Q_ROW,
    ST_Q_LOAD,
    ST_Q_WALK,
    ST_RESP
  } state_e;

endpackage

@@ rtl/bcne_if.sv @@
// valid/ready channel interfaces for operation requests and their results

interface bcne_in_if;
  import bcne_pkg::*;

  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [VERTEX_W-1:0] vertex;
  logic [VERTEX_W-1:0] other_vertex;
  logic [COLOUR_W-1:0] colour;
  logic [MASK_W-1:0]   colour_mask;
  logic [SIZE_W-1:0]   target_size;

  modport source (
    output valid, func, vertex, other_vertex, colour, colour_mask, target_size,
    input  ready
  );
  modport sink (
    input  valid, func, vertex, other_vertex, colour, colour_mask, target_size,
    output ready
  );
endinterface

interface bcne_out_if;
  import bcne_pkg::*;

  logic               valid;
  logic               ready;
  logic               error;
  logic [MASK_W-1:0]  union_mask;
  logic [MASK_W-1:0]  unfixed_mask;
  logic [MASK_W-1:0]  fixed_mask;
  logic [COUNT_W-1:0] colour_neighbour_count;
  logic [COUNT_W-1:0] pinned_neighbour_count;
  logic [MASK_W-1:0]  chosen_mask;

  modport source (
    output valid, error, union_mask, unfixed_mask, fixed_mask,
           colour_neighbour_count, pinned_neighbour_count, chosen_mask,
    input  ready
  );
  modport sink (
    input  valid, error, union_mask, unfixed_mask, fixed_mask,
           colour_neighbour_count, pinned_neighbour_count, chosen_mask,
    output ready
  );
endinterface

@@ rtl/bcne_ram.sv @@
// generic single-write single-read synchronous ram with registered read data
module bcne_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port, read data holds when idle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/bcne_choose.sv @@
// builds the chosen colour set of a requested size from the neighbourhood union
module bcne_choose #(
  parameter int NUM_COLOURS = bcne_pkg::COLOURS_DEFAULT
) (
  input  logic [NUM_COLOURS-1:0]             union_i,
  input  logic [$clog2(NUM_COLOURS+1)-1:0]   size_i,
  output logic [NUM_COLOURS-1:0]             chosen_o
);
  import bcne_pkg::*;

  localparam int SZ_W = $clog2(NUM_COLOURS + 1);

  // population count over the colour set
  function automatic logic [SZ_W-1:0] ones(input logic [NUM_COLOURS-1:0] x);
    logic [SZ_W-1:0] n;
    n = '0;
    for (int k = 0; k < NUM_COLOURS; k++) begin
      n = n + SZ_W'(x[k]);
    end
    return n;
  endfunction

  logic [SZ_W-1:0] total;
  logic [SZ_W-1:0] set_below [NUM_COLOURS];
  logic [SZ_W-1:0] clr_below [NUM_COLOURS];
  logic [SZ_W-1:0] missing;
  logic            short;

  // keep set bits ranked below the size, then clear bits ranked below the shortfall
  always_comb begin
    total   = ones(union_i);
    short   = total < size_i;
    missing = size_i - total;
    for (int i = 0; i < NUM_COLOURS; i++) begin
      set_below[i] = ones(union_i & ((NUM_COLOURS'(1) << i) - NUM_COLOURS'(1)));
      clr_below[i] = SZ_W'(i) - set_below[i];
      if (union_i[i]) begin
        chosen_o[i] = set_below[i] < size_i;
      end else begin
        chosen_o[i] = short && (clr_below[i] < missing);
      end
    end
  end

endmodule

@@ rtl/bounding_chain_neighbourhood_engine.sv @@
// top level of the bounding-chain neighbourhood engine: sequencer, datapath and memories
//
// The engine keeps a graph's adjacency rows in one ram (one row per vertex) and each vertex's
// bounding colour list together with its colour in a second ram. After reset a clearing pass
// over every vertex initializes both rams; no transaction is taken in the meantime. One
// request is worked at a time: add edge makes two read-modify-write passes on the adjacency
// ram, set bounding list and set colour make one read-modify-write on the attribute ram, and a
// query reads the vertex's adjacency row and then walks over every vertex's attribute entry at
// one read per cycle. Requests with an out-of-range vertex go straight to the result. A finished
// result sits in an output register, so the next request is taken while it waits to be collected.
module bounding_chain_neighbourhood_engine #(
  parameter int NUM_VERTICES = bcne_pkg::VERTICES_DEFAULT,
  parameter int NUM_COLOURS  = bcne_pkg::COLOURS_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bcne_in_if.sink    in_i,
  bcne_out_if.source out_o
);
  import bcne_pkg::*;

  localparam int AW   = $clog2(NUM_VERTICES);
  localparam int AT_W = NUM_COLOURS + COLOUR_W;
  localparam int SZ_W = $clog2(NUM_COLOURS + 1);
  localparam logic [AW-1:0]   N_LAST     = AW'(NUM_VERTICES - 1);
  localparam logic [AT_W-1:0] ATTR_RESET = {{COLOUR_W{1'b0}}, {NUM_COLOURS{1'b1}}};

  state_e state_q, state_d;
  logic [AW-1:0] n_q, n_d;

  // captured request
  func_e                  func_q;
  logic [AW-1:0]          v_q;
  logic [AW-1:0]          w_q;
  logic [COLOUR_W-1:0]    colour_q;
  logic [NUM_COLOURS-1:0] c_onehot_q;
  logic [NUM_COLOURS-1:0] list_q;
  logic [SZ_W-1:0]        size_q;
  logic                   error_q;

  // query accumulators
  logic [NUM_VERTICES-1:0] row_q;
  logic [NUM_COLOURS-1:0]  union_q;
  logic [NUM_COLOURS-1:0]  unfixed_q;
  logic [COUNT_W-1:0]      ccount_q;
  logic [COUNT_W-1:0]      pcount_q;

  // result register
  logic               out_valid_q;
  logic               out_error_q;
  logic [MASK_W-1:0]  out_union_q;
  logic [MASK_W-1:0]  out_unfixed_q;
  logic [MASK_W-1:0]  out_fixed_q;
  logic [COUNT_W-1:0] out_ccount_q;
  logic [COUNT_W-1:0] out_pcount_q;
  logic [MASK_W-1:0]  out_chosen_q;

  // memory ports
  logic                    adj_we, adj_re;
  logic [AW-1:0]           adj_waddr, adj_raddr;
  logic [NUM_VERTICES-1:0] adj_wdata, adj_rdata;
  logic                    attr_we, attr_re;
  logic [AW-1:0]           attr_waddr, attr_raddr;
  logic [AT_W-1:0]         attr_wdata, attr_rdata;

  // decoded request fields
  func_e                  in_func;
  logic                   in_acc;
  logic                   v_ok_in;
  logic                   w_ok_in;
  logic [SZ_W-1:0]        size_sat;

  // decoded attribute entry
  logic [NUM_COLOURS-1:0] rd_list;
  logic [COLOUR_W-1:0]    rd_colour;
  logic                   colour_ok;
  logic                   rd_multi;
  logic                   c_ok;
  logic                   out_load;
  logic [NUM_COLOURS-1:0] chosen;
  logic [NUM_COLOURS-1:0] fixed;

  assign in_func  = func_e'(in_i.func);
  assign in_acc   = in_i.valid && in_i.ready;
  assign v_ok_in  = int'(in_i.vertex) < NUM_VERTICES;
  assign w_ok_in  = int'(in_i.other_vertex) < NUM_VERTICES;
  assign size_sat = (int'(in_i.target_size) > NUM_COLOURS) ? SZ_W'(NUM_COLOURS)
                                                           : SZ_W'(in_i.target_size);

  assign rd_list   = attr_rdata[NUM_COLOURS-1:0];
  assign rd_colour = attr_rdata[AT_W-1:NUM_COLOURS];
  assign colour_ok = |(rd_list & c_onehot_q);
  assign rd_multi  = |(rd_list & (rd_list - NUM_COLOURS'(1)));
  assign c_ok      = |c_onehot_q;

  // fixed colours only span the configured colour range
  assign fixed = ~unfixed_q;

  // memories
  bcne_ram #(
    .WIDTH (NUM_VERTICES),
    .DEPTH (NUM_VERTICES)
  ) u_adj_ram (
    .clk_i   (clk_i),
    .we_i    (adj_we),
    .waddr_i (adj_waddr),
    .wdata_i (adj_wdata),
    .re_i    (adj_re),
    .raddr_i (adj_raddr),
    .rdata_o (adj_rdata)
  );

  bcne_ram #(
    .WIDTH (AT_W),
    .DEPTH (NUM_VERTICES)
  ) u_attr_ram (
    .clk_i   (clk_i),
    .we_i    (attr_we),
    .waddr_i (attr_waddr),
    .wdata_i (attr_wdata),
    .re_i    (attr_re),
    .raddr_i (attr_raddr),
    .rdata_o (attr_rdata)
  );

  // chosen set from the finished union
  bcne_choose #(
    .NUM_COLOURS (NUM_COLOURS)
  ) u_choose (
    .union_i  (union_q),
    .size_i   (size_q),
    .chosen_o (chosen)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (n_q == N_LAST) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          case (in_func)
            FUNC_ADD_EDGE:                  state_d = (v_ok_in && w_ok_in) ? ST_EDGE_RD_V : ST_RESP;
            FUNC_SET_LIST, FUNC_SET_COLOUR: state_d = v_ok_in ? ST_ATTR_RD : ST_RESP;
            FUNC_QUERY:                     state_d = v_ok_in ? ST_Q_ROW : ST_RESP;
            default:                        state_d = ST_RESP;
          endcase
        end
      end
      ST_EDGE_RD_V: state_d = ST_EDGE_WR_V;
      ST_EDGE_WR_V: state_d = ST_EDGE_RD_W;
      ST_EDGE_RD_W: state_d = ST_EDGE_WR_W;
      ST_EDGE_WR_W: state_d = ST_RESP;
      ST_ATTR_RD:   state_d = ST_ATTR_WR;
      ST_ATTR_WR:   state_d = ST_RESP;
      ST_Q_ROW:     state_d = ST_Q_LOAD;
      ST_Q_LOAD:    state_d = ST_Q_WALK;
      ST_Q_WALK: begin
        if (n_q == N_LAST) state_d = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_q || out_o.ready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // memory controls, counter and handshake outputs
  always_comb begin
    adj_we     = 1'b0;
    adj_waddr  = v_q;
    adj_wdata  = '0;
    adj_re     = 1'b0;
    adj_raddr  = v_q;
    attr_we    = 1'b0;
    attr_waddr = v_q;
    attr_wdata = ATTR_RESET;
    attr_re    = 1'b0;
    attr_raddr = v_q;
    n_d        = n_q;
    in_i.ready = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        adj_we     = 1'b1;
        adj_waddr  = n_q;
        attr_we    = 1'b1;
        attr_waddr = n_q;
        n_d        = (n_q == N_LAST) ? '0 : n_q + AW'(1);
      end
      ST_IDLE: in_i.ready = 1'b1;
      ST_EDGE_RD_V: adj_re = 1'b1;
      ST_EDGE_WR_V: begin
        adj_we    = 1'b1;
        adj_wdata = adj_rdata | (NUM_VERTICES'(1) << w_q);
      end
      ST_EDGE_RD_W: begin
        adj_re    = 1'b1;
        adj_raddr = w_q;
      end
      ST_EDGE_WR_W: begin
        adj_we    = 1'b1;
        adj_waddr = w_q;
        adj_wdata = adj_rdata | (NUM_VERTICES'(1) << v_q);
      end
      ST_ATTR_RD: attr_re = 1'b1;
      ST_ATTR_WR: begin
        if (func_q == FUNC_SET_LIST) begin
          attr_we    = 1'b1;
          attr_wdata = {rd_colour, list_q};
        end else if (func_q == FUNC_SET_COLOUR && colour_ok) begin
          attr_we    = 1'b1;
          attr_wdata = {colour_q, rd_list};
        end
      end
      ST_Q_ROW: adj_re = 1'b1;
      ST_Q_LOAD: begin
        attr_re    = 1'b1;
        attr_raddr = '0;
        n_d        = '0;
      end
      ST_Q_WALK: begin
        if (n_q != N_LAST) begin
          attr_re    = 1'b1;
          attr_raddr = n_q + AW'(1);
          n_d        = n_q + AW'(1);
        end
      end
      ST_RESP: out_load = !out_valid_q || out_o.ready;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // request capture, read-modify-write status and neighbourhood walk
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          func_q     <= in_func;
          v_q        <= AW'(in_i.vertex);
          w_q        <= AW'(in_i.other_vertex);
          colour_q   <= in_i.colour;
          c_onehot_q <= NUM_COLOURS'(1) << in_i.colour;
          list_q     <= NUM_COLOURS'(in_i.colour_mask);
          size_q     <= size_sat;
          error_q    <= (in_func == FUNC_SET_COLOUR) && !v_ok_in;
          union_q    <= '0;
          unfixed_q  <= '0;
          ccount_q   <= '0;
          pcount_q   <= '0;
        end
      end
      ST_ATTR_WR: begin
        if (func_q == FUNC_SET_COLOUR) error_q <= !colour_ok;
      end
      ST_Q_LOAD: row_q <= adj_rdata;
      ST_Q_WALK: begin
        row_q <= row_q >> 1;
        if (row_q[0]) begin
          union_q <= union_q | rd_list;
          if (rd_multi) unfixed_q <= unfixed_q | rd_list;
          if (c_ok && rd_colour == colour_q) ccount_q <= ccount_q + COUNT_W'(1);
          if (c_ok && rd_list == c_onehot_q) pcount_q <= pcount_q + COUNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  // result register, only a query reports neighbourhood fields
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_error_q <= error_q;
      if (func_q == FUNC_QUERY) begin
        out_union_q   <= MASK_W'(union_q);
        out_unfixed_q <= MASK_W'(unfixed_q);
        out_fixed_q   <= MASK_W'(fixed);
        out_ccount_q  <= ccount_q;
        out_pcount_q  <= pcount_q;
        out_chosen_q  <= MASK_W'(chosen);
      end else begin
        out_union_q   <= '0;
        out_unfixed_q <= '0;
        out_fixed_q   <= '0;
        out_ccount_q  <= '0;
        out_pcount_q  <= '0;
        out_chosen_q  <= '0;
      end
    end
  end

  assign out_o.valid                  = out_valid_q;
  assign out_o.error                  = out_error_q;
  assign out_o.union_mask             = out_union_q;
  assign out_o.unfixed_mask           = out_unfixed_q;
  assign out_o.fixed_mask             = out_fixed_q;
  assign out_o.colour_neighbour_count = out_ccount_q;
  assign out_o.pinned_neighbour_count = out_pcount_q;
  assign out_o.chosen_mask            = out_chosen_q;

  // no same-cycle read and write of one attribute entry
  a_attr_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(attr_we && attr_re && attr_waddr == attr_raddr))
    else $error("attribute ram read and written at the same entry");

  // no same-cycle read and write of one adjacency row
  a_adj_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(adj_we && adj_re && adj_waddr == adj_raddr))
    else $error("adjacency ram read and written at the same row");

  // a refused colour write leaves the attribute ram untouched
  a_refused_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ATTR_WR && func_q == FUNC_SET_COLOUR && !colour_ok) |-> !attr_we)
    else $error("refused colour write reached the attribute ram");

  // the walk consumes every adjacency bit of the row
  a_row_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_Q_WALK && n_q == N_LAST) |=> (state_q == ST_RESP && row_q == '0))
    else $error("neighbourhood walk ended with adjacency bits left over");

endmodule

@@ bench/testbench.sv @@
// self-checking bench for the bounding-chain neighbourhood engine
`timescale 1ns / 1ps

module testbench;
  import bcne_pkg::*;

  localparam int N_VERT = VERTICES_DEFAULT;
  localparam int N_COL  = COLOURS_DEFAULT;
  localparam logic [MASK_W-1:0] ALL_COLOURS = MASK_W'((1 << N_COL) - 1);
  localparam int RANDOM_REQUESTS = 850;

  typedef struct packed {
    func_e               func;
    logic [VERTEX_W-1:0] vertex;
    logic [VERTEX_W-1:0] other_vertex;
    logic [COLOUR_W-1:0] colour;
    logic [MASK_W-1:0]   colour_mask;
    logic [SIZE_W-1:0]   target_size;
  } request_t;

  typedef struct packed {
    logic               error;
    logic [MASK_W-1:0]  union_mask;
    logic [MASK_W-1:0]  unfixed_mask;
    logic [MASK_W-1:0]  fixed_mask;
    logic [COUNT_W-1:0] colour_count;
    logic [COUNT_W-1:0] pinned_count;
    logic [MASK_W-1:0]  chosen_mask;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  bcne_in_if  req_if ();
  bcne_out_if rsp_if ();

  bounding_chain_neighbourhood_engine #(
    .NUM_VERTICES(N_VERT),
    .NUM_COLOURS (N_COL)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_if),
    .out_o (rsp_if)
  );

  // graph copy that tracks accepted transactions
  logic [N_VERT-1:0] adj_rows   [N_VERT];
  logic [MASK_W-1:0] list_of    [N_VERT];
  logic [COLOUR_W-1:0] colour_of [N_VERT];

  // list contents as the stimulus expects them once its writes land
  logic [MASK_W-1:0] planned_lists [N_VERT];

  request_t pending_requests [$];
  result_t  expected_results [$];
  request_t current_req;
  result_t  wanted_result;
  result_t  checked_result;

  int total_requests;
  int accepted_count;
  int results_checked;
  int mismatch_count;
  int refused_count;
  int op_count [4];
  int burst_left;
  int gap_left;
  int stall_cycle;

  // apply one transaction to the graph copy and return what the engine should answer
  function automatic result_t apply_request(request_t rq);
    result_t rs;
    logic [MASK_W-1:0] bl;
    logic [MASK_W-1:0] uni;
    logic [MASK_W-1:0] unfixed;
    logic [MASK_W-1:0] chosen;
    int ones;
    int ccount;
    int pcount;
    int kept;
    int wanted;
    rs = '0;
    uni = '0;
    unfixed = '0;
    chosen = '0;
    ccount = 0;
    pcount = 0;
    kept = 0;
    case (rq.func)
      FUNC_ADD_EDGE: begin
        if (rq.vertex < N_VERT && rq.other_vertex < N_VERT) begin
          adj_rows[rq.vertex][rq.other_vertex] = 1'b1;
          adj_rows[rq.other_vertex][rq.vertex] = 1'b1;
        end
      end
      FUNC_SET_LIST: begin
        if (rq.vertex < N_VERT) list_of[rq.vertex] = rq.colour_mask & ALL_COLOURS;
      end
      FUNC_SET_COLOUR: begin
        if (rq.vertex < N_VERT && rq.colour < N_COL && list_of[rq.vertex][rq.colour])
          colour_of[rq.vertex] = rq.colour;
        else
          rs.error = 1'b1;
      end
      default: begin
        // walk the neighbourhood
        if (rq.vertex < N_VERT) begin
          for (int n = 0; n < N_VERT; n++) begin
            if (adj_rows[rq.vertex][n]) begin
              bl = list_of[n];
              ones = $countones(bl);
              uni |= bl;
              if (ones > 1) unfixed |= bl;
              if (rq.colour < N_COL) begin
                if (colour_of[n] == rq.colour) ccount++;
                if (ones == 1 && bl[rq.colour]) pcount++;
              end
            end
          end
        end
        // keep lowest union bits, then pad with lowest free colours
        wanted = (rq.target_size > N_COL) ? N_COL : int'(rq.target_size);
        for (int n = 0; n < N_COL && kept < wanted; n++) begin
          if (uni[n]) begin
            chosen[n] = 1'b1;
            kept++;
          end
        end
        for (int n = 0; n < N_COL && kept < wanted; n++) begin
          if (!chosen[n]) begin
            chosen[n] = 1'b1;
            kept++;
          end
        end
        rs.union_mask   = uni;
        rs.unfixed_mask = unfixed;
        rs.fixed_mask   = ~unfixed & ALL_COLOURS;
        rs.colour_count = ccount[COUNT_W-1:0];
        rs.pinned_count = pcount[COUNT_W-1:0];
        rs.chosen_mask  = chosen;
      end
    endcase
    return rs;
  endfunction

  function automatic void queue_request(func_e f, int v, int w, int c, int m, int s);
    request_t rq;
    rq.func         = f;
    rq.vertex       = VERTEX_W'(v);
    rq.other_vertex = VERTEX_W'(w);
    rq.colour       = COLOUR_W'(c);
    rq.colour_mask  = MASK_W'(m);
    rq.target_size  = SIZE_W'(s);
    if (f == FUNC_SET_LIST) planned_lists[v] = rq.colour_mask & ALL_COLOURS;
    pending_requests.insert(pending_requests.size(), rq);
  endfunction

  // half of them singletons so pinned neighbours show up, the rest full, empty and arbitrary lists
  function automatic int random_list();
    case ($urandom_range(0, 7))
      0, 1, 2, 3: return 1 << $urandom_range(0, N_COL - 1);
      4:          return int'(ALL_COLOURS);
      5:          return 0;
      default:    return $urandom_range(0, (1 << MASK_W) - 1);
    endcase
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // request driver: bursts of transactions separated by random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid        <= 1'b0;
      req_if.func         <= FUNC_ADD_EDGE;
      req_if.vertex       <= '0;
      req_if.other_vertex <= '0;
      req_if.colour       <= '0;
      req_if.colour_mask  <= '0;
      req_if.target_size  <= '0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        wanted_result = apply_request(current_req);
        if (wanted_result.error) refused_count++;
        expected_results.insert(expected_results.size(), wanted_result);
        op_count[current_req.func]++;
        accepted_count++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (gap_left > 0 || pending_requests.size() == 0) begin
          if (gap_left > 0) gap_left--;
          req_if.valid <= 1'b0;
        end else begin
          current_req = pending_requests.pop_front();
          req_if.valid        <= 1'b1;
          req_if.func         <= current_req.func;
          req_if.vertex       <= current_req.vertex;
          req_if.other_vertex <= current_req.other_vertex;
          req_if.colour       <= current_req.colour;
          req_if.colour_mask  <= current_req.colour_mask;
          req_if.target_size  <= current_req.target_size;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end
        end
      end
    end
  end

  // result monitor with its own stall pattern
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      stall_cycle = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with no transaction outstanding", $time);
          mismatch_count++;
        end else begin
          checked_result = expected_results.pop_front();
          check_field("error", 32'(checked_result.error), 32'(rsp_if.error));
          check_field("union_mask", 32'(checked_result.union_mask), 32'(rsp_if.union_mask));
          check_field("unfixed_mask", 32'(checked_result.unfixed_mask),
                      32'(rsp_if.unfixed_mask));
          check_field("fixed_mask", 32'(checked_result.fixed_mask), 32'(rsp_if.fixed_mask));
          check_field("colour_neighbour_count", 32'(checked_result.colour_count),
                      32'(rsp_if.colour_neighbour_count));
          check_field("pinned_neighbour_count", 32'(checked_result.pinned_count),
                      32'(rsp_if.pinned_neighbour_count));
          check_field("chosen_mask", 32'(checked_result.chosen_mask),
                      32'(rsp_if.chosen_mask));
          results_checked++;
        end
      end
      stall_cycle++;
      // rotate through always-ready, light, sparse and long-stall phases
      case ((stall_cycle >> 8) & 3)
        0:       rsp_if.ready <= 1'b1;
        1:       rsp_if.ready <= ($urandom_range(0, 3) != 0);
        2:       rsp_if.ready <= (stall_cycle % 7 == 0);
        default: rsp_if.ready <= (stall_cycle % 64) >= 30;
      endcase
    end
  end

  // stimulus and end of run
  initial begin
    int r;
    int v;
    int c;
    rst_ni = 1'b0;
    accepted_count = 0;
    results_checked = 0;
    mismatch_count = 0;
    refused_count = 0;
    for (int i = 0; i < 4; i++) op_count[i] = 0;
    for (int i = 0; i < N_VERT; i++) begin
      adj_rows[i] = '0;
      list_of[i] = ALL_COLOURS;
      colour_of[i] = '0;
      planned_lists[i] = ALL_COLOURS;
    end

    // directed: empty neighbourhood, saturation, self loops, refusals, extremes
    queue_request(FUNC_QUERY, 5, 0, 0, 0, 0);
    queue_request(FUNC_QUERY, 5, 0, 15, 0, 15);
    queue_request(FUNC_ADD_EDGE, 5, 5, 0, 0, 0);
    queue_request(FUNC_ADD_EDGE, 5, 63, 0, 0, 0);
    queue_request(FUNC_ADD_EDGE, 0, 63, 0, 0, 0);
    queue_request(FUNC_SET_LIST, 63, 0, 0, 10'h008, 0);
    queue_request(FUNC_SET_LIST, 5, 0, 0, 10'h300, 0);
    queue_request(FUNC_SET_COLOUR, 63, 0, 3, 0, 0);
    queue_request(FUNC_SET_COLOUR, 63, 0, 4, 0, 0);
    queue_request(FUNC_SET_COLOUR, 5, 0, 12, 0, 0);
    queue_request(FUNC_SET_COLOUR, 5, 0, 9, 0, 0);
    queue_request(FUNC_SET_LIST, 0, 0, 0, 0, 0);
    queue_request(FUNC_SET_COLOUR, 0, 0, 0, 0, 0);
    queue_request(FUNC_QUERY, 5, 0, 3, 0, 3);
    queue_request(FUNC_QUERY, 5, 0, 9, 0, 10);
    queue_request(FUNC_QUERY, 63, 0, 3, 0, 1);
    queue_request(FUNC_QUERY, 0, 0, 0, 0, 7);
    queue_request(FUNC_QUERY, 5, 0, 10, 0, 2);
    queue_request(FUNC_ADD_EDGE, 5, 0, 0, 0, 0);
    queue_request(FUNC_SET_LIST, 63, 0, 0, 10'h3ff, 0);
    queue_request(FUNC_QUERY, 5, 0, 3, 0, 12);
    queue_request(FUNC_QUERY, 63, 0, 0, 0, 15);
    queue_request(FUNC_ADD_EDGE, 63, 63, 0, 0, 0);
    queue_request(FUNC_QUERY, 63, 0, 9, 0, 4);

    // random mix: build the graph while querying it
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      r = $urandom_range(0, 99);
      v = $urandom_range(0, N_VERT - 1);
      if (r < 20) begin
        queue_request(FUNC_ADD_EDGE, v,
                      ($urandom_range(0, 19) == 0) ? v : $urandom_range(0, N_VERT - 1),
                      $urandom_range(0, 15), $urandom_range(0, 1023), $urandom_range(0, 15));
      end else if (r < 40) begin
        queue_request(FUNC_SET_LIST, v, $urandom_range(0, N_VERT - 1),
                      $urandom_range(0, 15), random_list(), $urandom_range(0, 15));
      end else if (r < 60) begin
        // mostly a colour the list allows, sometimes anything
        if (planned_lists[v] != '0 && $urandom_range(0, 4) != 0) begin
          do c = $urandom_range(0, N_COL - 1); while (!planned_lists[v][c]);
        end else begin
          c = $urandom_range(0, 15);
        end
        queue_request(FUNC_SET_COLOUR, v, $urandom_range(0, N_VERT - 1), c,
                      $urandom_range(0, 1023), $urandom_range(0, 15));
      end else begin
        c = ($urandom_range(0, 9) == 0) ? $urandom_range(N_COL, 15) : $urandom_range(0, N_COL - 1);
        queue_request(FUNC_QUERY, v, $urandom_range(0, N_VERT - 1), c,
                      $urandom_range(0, 1023), $urandom_range(0, 15));
      end
    end
    total_requests = pending_requests.size();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (accepted_count < total_requests || expected_results.size() != 0) @(posedge clk_i);
    repeat (N_VERT + 40) @(posedge clk_i);

    $display("covered %0d transactions: %0d edges, %0d list writes, %0d colour writes, %0d queries",
             accepted_count, op_count[FUNC_ADD_EDGE], op_count[FUNC_SET_LIST],
             op_count[FUNC_SET_COLOUR], op_count[FUNC_QUERY]);
    $display("%0d results checked, %0d colour writes refused", results_checked, refused_count);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
